// File: src/rsa_modexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsa_modexp_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int CNT_W      = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
    localparam int ADDR_W     = 4;
    localparam int PDATA_W    = 32;

    // register index codes, word addressed by paddr[3:2]
    localparam logic [1:0] REG_MODULUS     = 2'd0;
    localparam logic [1:0] REG_PUBLIC_EXP  = 2'd1;
    localparam logic [1:0] REG_PRIVATE_EXP = 2'd2;

    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_BASE,
        S_CHECK,
        S_ITER,
        S_COMMIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic reduce;
        logic commit_red;
        logic start_iter;
        logic commit_iter;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic range_err;
        logic expo_zero;
    } stat_t;

endpackage

`default_nettype wire

// File: src/rsa_modexp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rsa_modexp_ctrl
    import rsa_modexp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  wire logic  out_stall,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(DATA_WIDTH - 1);
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                cmd.step   = 1'b1;
                cmd.reduce = 1'b1;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                cmd.commit_red = 1'b1;
                state_next     = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.range_err || stat.expo_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.start_iter = 1'b1;
                    cnt_next       = CNT_W'(DATA_WIDTH - 1);
                    state_next     = S_ITER;
                end
            end
            S_ITER:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit_iter = 1'b1;
                state_next      = S_CHECK;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: src/rsa_modexp_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rsa_modexp_dp
    import rsa_modexp_pkg::*;
(
    input  wire logic                  clk,
    input  wire cmd_t                  cmd,
    input  wire logic                  action,
    input  wire logic [DATA_WIDTH-1:0] data_value,
    input  wire logic [DATA_WIDTH-1:0] modulus,
    input  wire logic [DATA_WIDTH-1:0] public_exponent,
    input  wire logic [DATA_WIDTH-1:0] private_exponent,
    output stat_t                      stat,
    output logic [DATA_WIDTH-1:0]      result_value,
    output logic                       range_error
);

    // one interleaved shift-add step: (2r + bit*a) mod n, with r, a below n
    function automatic logic [DATA_WIDTH-1:0] mm_step(
        input logic [DATA_WIDTH-1:0] r,
        input logic [DATA_WIDTH-1:0] a,
        input logic                  b,
        input logic [DATA_WIDTH-1:0] n
    );
        logic [DATA_WIDTH:0] d;
        logic [DATA_WIDTH:0] s;
        logic [DATA_WIDTH:0] ne;
        ne = {1'b0, n};
        d  = {r, 1'b0};
        if (d >= ne)
        begin
            d = d - ne;
        end
        s = d + (b ? {1'b0, a} : '0);
        if (s >= ne)
        begin
            s = s - ne;
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    logic [DATA_WIDTH-1:0] base_reg, base_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic [DATA_WIDTH-1:0] expo_reg, expo_next;
    logic [DATA_WIDTH-1:0] ra_reg, ra_next;
    logic [DATA_WIDTH-1:0] rb_reg, rb_next;
    logic [DATA_WIDTH-1:0] ma_reg, ma_next;
    logic [DATA_WIDTH-1:0] mb_reg, mb_next;
    logic [DATA_WIDTH-1:0] res_reg, res_next;
    logic                  err_reg, err_next;
    logic                  zmod_reg, zmod_next;
    logic                  rerr_reg, rerr_next;
    logic [DATA_WIDTH-1:0] mcand_b;

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        acc_reg  <= acc_next;
        expo_reg <= expo_next;
        ra_reg   <= ra_next;
        rb_reg   <= rb_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        res_reg  <= res_next;
        err_reg  <= err_next;
        zmod_reg <= zmod_next;
        rerr_reg <= rerr_next;
    end

    always_comb
    begin
        base_next = base_reg;
        acc_next  = acc_reg;
        expo_next = expo_reg;
        ra_next   = ra_reg;
        rb_next   = rb_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        res_next  = res_reg;
        err_next  = err_reg;
        zmod_next = zmod_reg;
        rerr_next = rerr_reg;
        // reduction of the input value runs as 1 * value mod n
        mcand_b   = cmd.reduce ? DATA_WIDTH'(1) : base_reg;

        if (cmd.load)
        begin
            expo_next = (action == ACT_DECRYPT) ? private_exponent : public_exponent;
            err_next  = (action == ACT_ENCRYPT) && (data_value >= modulus);
            zmod_next = (modulus == '0);
            acc_next  = DATA_WIDTH'(1);
            rb_next   = '0;
            mb_next   = data_value;
        end
        if (cmd.step)
        begin
            ra_next = mm_step(ra_reg, base_reg, ma_reg[DATA_WIDTH-1], modulus);
            rb_next = mm_step(rb_reg, mcand_b, mb_reg[DATA_WIDTH-1], modulus);
            ma_next = {ma_reg[DATA_WIDTH-2:0], 1'b0};
            mb_next = {mb_reg[DATA_WIDTH-2:0], 1'b0};
        end
        if (cmd.commit_red)
        begin
            base_next = rb_reg;
        end
        if (cmd.start_iter)
        begin
            ra_next = '0;
            rb_next = '0;
            ma_next = acc_reg;
            mb_next = base_reg;
        end
        if (cmd.commit_iter)
        begin
            if (expo_reg[0])
            begin
                acc_next = zmod_reg ? '0 : ra_reg;
            end
            base_next = rb_reg;
            expo_next = {1'b0, expo_reg[DATA_WIDTH-1:1]};
        end
        if (cmd.out_load)
        begin
            res_next  = err_reg ? '0 : acc_reg;
            rerr_next = err_reg;
        end
    end

    assign stat.range_err = err_reg;
    assign stat.expo_zero = (expo_reg == '0);
    assign result_value   = res_reg;
    assign range_error    = rerr_reg;

endmodule

`default_nettype wire

// File: src/rsa_modular_exponentiation.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// input     in         in_valid / in_stall  action, data_value
// output    out        out_valid/out_stall  result_value, range_error
// config    in         apb write/read       modulus, public_exponent, private_exponent
//
// one item at a time; the exponent loop runs once per exponent bit up to the highest set one,
// and not at all on range error or zero exponent
// the modular multiply is bit-serial: one multiplier bit per cycle
// rst_n clears the controller and output valid and loads the register reset values
// a finished result waits in the output register; the next item is taken meanwhile

module rsa_modular_exponentiation
    import rsa_modexp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  action,
    input  wire logic [DATA_WIDTH-1:0] data_value,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [DATA_WIDTH-1:0]      result_value,
    output logic                       range_error,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready
);

    logic [DATA_WIDTH-1:0] modulus_reg;
    logic [DATA_WIDTH-1:0] pub_exp_reg;
    logic [DATA_WIDTH-1:0] priv_exp_reg;
    logic                  cfg_wr;
    cmd_t                  cmd;
    stat_t                 stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= DATA_WIDTH'(2);
            pub_exp_reg  <= DATA_WIDTH'(1);
            priv_exp_reg <= DATA_WIDTH'(1);
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_MODULUS:     modulus_reg  <= pwdata[DATA_WIDTH-1:0];
                REG_PUBLIC_EXP:  pub_exp_reg  <= pwdata[DATA_WIDTH-1:0];
                REG_PRIVATE_EXP: priv_exp_reg <= pwdata[DATA_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MODULUS:     prdata = PDATA_W'(modulus_reg);
            REG_PUBLIC_EXP:  prdata = PDATA_W'(pub_exp_reg);
            REG_PRIVATE_EXP: prdata = PDATA_W'(priv_exp_reg);
            default:         prdata = '0;
        endcase
    end

    rsa_modexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    rsa_modexp_dp u_dp (
        .clk              (clk),
        .cmd              (cmd),
        .action           (action),
        .data_value       (data_value),
        .modulus          (modulus_reg),
        .public_exponent  (pub_exp_reg),
        .private_exponent (priv_exp_reg),
        .stat             (stat),
        .result_value     (result_value),
        .range_error      (range_error)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while an item is in progress");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && range_error) |-> (result_value == '0))
        else $error("range error with nonzero result");

    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !range_error && (modulus_reg > DATA_WIDTH'(1)))
            |-> (result_value < modulus_reg))
        else $error("result not below modulus");

    a_new_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in progress");

endmodule

`default_nettype wire

// File: bench/rsa_modular_exponentiation_tb.sv
`timescale 1ns / 1ps

module rsa_modular_exponentiation_tb
    import rsa_modexp_pkg::*;
();

    localparam int          CYCLE_LIMIT = 2_500_000;
    localparam int          NUM_ITEMS   = 1450;
    localparam int          TAIL_CYCLES = 400;
    localparam logic [1:0]  REG_UNUSED  = 2'd3;

    typedef struct packed {
        logic                  act;
        logic [DATA_WIDTH-1:0] val;
    } crypto_item_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic                  err;
    } crypto_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  action = ACT_ENCRYPT;
    logic [DATA_WIDTH-1:0] data_value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [DATA_WIDTH-1:0] result_value;
    logic                  range_error;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    // key registers as the predictor sees them
    logic [DATA_WIDTH-1:0] cur_modulus  = 16'd2;
    logic [DATA_WIDTH-1:0] cur_pub_exp  = 16'd1;
    logic [DATA_WIDTH-1:0] cur_priv_exp = 16'd1;

    crypto_item_t   crypto_items[$];
    crypto_result_t expected_results[$];
    crypto_item_t   next_item;

    int cycle_count    = 0;
    int mismatch_count = 0;
    int items_queued   = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int encrypt_count  = 0;
    int decrypt_count  = 0;
    int range_err_seen = 0;
    int key_settings   = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int stall_mode     = 0;
    int stall_left     = 0;

    rsa_modular_exponentiation DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .data_value   (data_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .range_error  (range_error),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("rsa_modular_exponentiation_tb failed");
            $finish;
        end
    end

    function automatic logic [31:0] mod_reduce(input logic [31:0] x);
        if (cur_modulus == '0)
            return '0;
        return x % {16'd0, cur_modulus};
    endfunction

    // right-to-left square and multiply at double width
    function automatic crypto_result_t modexp_predict(input logic act,
                                                      input logic [DATA_WIDTH-1:0] val);
        crypto_result_t        r;
        logic [31:0]           acc;
        logic [31:0]           base;
        logic [DATA_WIDTH-1:0] expo;
        r.err = 1'b0;
        r.value = '0;
        if (act == ACT_ENCRYPT && val >= cur_modulus)
        begin
            r.err = 1'b1;
            return r;
        end
        expo = (act == ACT_ENCRYPT) ? cur_pub_exp : cur_priv_exp;
        acc = 32'd1;
        base = {16'd0, val};
        while (expo != '0)
        begin
            if (expo[0])
                acc = mod_reduce(acc * base);
            base = mod_reduce(base * base);
            expo = expo >> 1;
        end
        r.value = acc[DATA_WIDTH-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 20)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
    endtask

    // sender: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(modexp_predict(action, data_value));
                items_sent++;
                if (action == ACT_ENCRYPT)
                    encrypt_count++;
                else
                    decrypt_count++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (crypto_items.size() > 0)
                begin
                    next_item = crypto_items.pop_front();
                    in_valid <= 1'b1;
                    action <= next_item.act;
                    data_value <= next_item.val;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 8);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: checks each transfer and stalls on a mode pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_mode = 0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (range_error)
                    range_err_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", int'(result_value), 0);
                else
                begin
                    crypto_result_t want;
                    want = expected_results.pop_front();
                    if (result_value !== want.value)
                        report_mismatch("result_value", int'(result_value),
                                        int'(want.value));
                    if (range_error !== want.err)
                        report_mismatch("range_error", int'(range_error), int'(want.err));
                end
            end
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(50, 300);
            end
            else
                stall_left--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 1) == 1);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (crypto_items.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [DATA_WIDTH-1:0] value);
        logic [PDATA_W-1:0] word;
        word = $urandom;
        word[DATA_WIDTH-1:0] = value;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MODULUS:     cur_modulus = value;
            REG_PUBLIC_EXP:  cur_pub_exp = value;
            REG_PRIVATE_EXP: cur_priv_exp = value;
            default: ;
        endcase
    endtask

    task automatic set_key(input logic [DATA_WIDTH-1:0] n, input logic [DATA_WIDTH-1:0] e,
                           input logic [DATA_WIDTH-1:0] d);
        wait_drained();
        apb_write(REG_MODULUS, n);
        apb_write(REG_PUBLIC_EXP, e);
        apb_write(REG_PRIVATE_EXP, d);
        if ($urandom_range(0, 3) == 0)
            apb_write(REG_UNUSED, DATA_WIDTH'($urandom));
        key_settings++;
    endtask

    task automatic queue_item(input logic act, input logic [DATA_WIDTH-1:0] val);
        crypto_item_t it;
        it.act = act;
        it.val = val;
        crypto_items.push_back(it);
        items_queued++;
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_exponent();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return DATA_WIDTH'($urandom_range(1, 3));
            3, 4: return DATA_WIDTH'($urandom_range(1, 255));
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    initial
    begin
        int                    phase_len;
        int                    sel;
        logic [DATA_WIDTH-1:0] n;
        logic [DATA_WIDTH-1:0] val;
        logic                  act;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset key values
        queue_item(ACT_ENCRYPT, 16'd0);
        queue_item(ACT_ENCRYPT, 16'd1);
        queue_item(ACT_ENCRYPT, 16'd2);
        queue_item(ACT_ENCRYPT, 16'hFFFF);
        queue_item(ACT_DECRYPT, 16'hFFFF);
        queue_item(ACT_DECRYPT, 16'd0);

        // largest modulus, all-ones public and zero private exponent
        set_key(16'hFFFF, 16'hFFFF, 16'd0);
        queue_item(ACT_ENCRYPT, 16'hFFFE);
        queue_item(ACT_ENCRYPT, 16'hFFFF);
        queue_item(ACT_DECRYPT, 16'h1234);
        queue_item(ACT_DECRYPT, 16'hFFFF);
        queue_item(ACT_ENCRYPT, 16'd0);

        // zero modulus
        set_key(16'd0, 16'd0, 16'd7);
        queue_item(ACT_ENCRYPT, 16'd0);
        queue_item(ACT_ENCRYPT, 16'hFFFF);
        queue_item(ACT_DECRYPT, 16'd5);
        queue_item(ACT_DECRYPT, 16'd0);

        // unit modulus, zero exponent stays unreduced
        set_key(16'd1, 16'd0, 16'hFFFF);
        queue_item(ACT_ENCRYPT, 16'd0);
        queue_item(ACT_ENCRYPT, 16'd1);
        queue_item(ACT_DECRYPT, 16'hFFFF);

        // textbook key pair plus a write past the register list
        set_key(16'd3233, 16'd17, 16'd2753);
        apb_write(REG_UNUSED, 16'hBEEF);
        queue_item(ACT_ENCRYPT, 16'd65);
        queue_item(ACT_DECRYPT, 16'd2790);
        queue_item(ACT_DECRYPT, 16'hFFFF);
        queue_item(ACT_ENCRYPT, 16'd3233);
        queue_item(ACT_ENCRYPT, 16'd3232);

        while (items_queued < NUM_ITEMS)
        begin
            sel = $urandom_range(0, 15);
            case (sel)
                0: n = 16'd0;
                1: n = 16'd1;
                2: n = 16'd2;
                3: n = 16'hFFFF;
                4, 5: n = DATA_WIDTH'($urandom_range(2, 255));
                default: n = DATA_WIDTH'($urandom_range(256, 65535));
            endcase
            set_key(n, pick_exponent(), pick_exponent());
            phase_len = $urandom_range(20, 80);
            for (int i = 0; i < phase_len; i++)
            begin
                act = 1'($urandom_range(0, 1));
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    val = '0;
                else if (sel == 1)
                    val = '1;
                else if (sel == 2)
                    val = cur_modulus - 1'b1;
                else if (sel == 3)
                    val = cur_modulus;
                else if (sel <= 6 || cur_modulus == '0)
                    val = DATA_WIDTH'($urandom);
                else
                    val = DATA_WIDTH'($urandom_range(0, cur_modulus - 1));
                queue_item(act, val);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never seen", 0, expected_results.size());

        $display("%0d transfers in, %0d results checked: %0d encrypt, %0d decrypt, %0d range errors",
                 items_sent, results_seen, encrypt_count, decrypt_count, range_err_seen);
        $display("%0d key settings incl. zero and unit modulus, zero and all-ones exponents",
                 key_settings);
        if (mismatch_count == 0)
            $display("rsa_modular_exponentiation_tb passed");
        else
            $display("rsa_modular_exponentiation_tb failed");
        $finish;
    end

endmodule
